// ===== rtl/jfps_pkg.sv =====
// ----------------------------------------------------------------------------
// jfps_pkg
// Shared types, constants and the bus sequence table of the flash sequencer.
// ----------------------------------------------------------------------------
package jfps_pkg;

    localparam int AddrBits = 17;
    localparam logic [16:0] AddrMask = 17'((18'd1 << AddrBits) - 18'd1);

    localparam int QueueDepth = 4;
    localparam int QPtrBits   = $clog2(QueueDepth);
    localparam int QCntBits   = $clog2(QueueDepth + 1);

    localparam logic [16:0] CmdAddrA = 17'h05555;
    localparam logic [16:0] CmdAddrB = 17'h02AAA;
    localparam logic [7:0]  CmdUnlockA  = 8'hAA;
    localparam logic [7:0]  CmdUnlockB  = 8'h55;
    localparam logic [7:0]  CmdResetRd  = 8'hF0;
    localparam logic [7:0]  CmdAutoId   = 8'h90;
    localparam logic [7:0]  CmdErase    = 8'h80;
    localparam logic [7:0]  CmdChipEra  = 8'h10;
    localparam logic [7:0]  CmdProgram  = 8'hA0;
    localparam logic [7:0]  ErasedByte  = 8'hFF;

    localparam logic [31:0] ErasePollReset = 32'd200000000;
    localparam logic [31:0] ProgPollReset  = 32'd2000000;
    localparam logic [17:0] PayloadReset   = 18'd131072;
    localparam logic [7:0]  MakerReset     = 8'd1;
    localparam logic [7:0]  DeviceReset    = 8'd32;
    localparam logic [17:0] CountMax       = 18'h3FFFF;

    localparam logic [2:0] CFG_PAYLOAD_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_ERASE_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_PROGRAM_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_EXPECTED_MAKER  = 3'd3;
    localparam logic [2:0] CFG_EXPECTED_DEVICE = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDENTIFY = 3'd0,
        MODE_RESET    = 3'd1,
        MODE_ERASE    = 3'd2,
        MODE_PROGRAM  = 3'd3,
        MODE_RESPONSE = 3'd4,
        MODE_COMPARE  = 3'd5,
        MODE_CLEAR    = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        STS_ACCEPTED   = 4'd0,
        STS_POLLING    = 4'd1,
        STS_ID_OK      = 4'd2,
        STS_ID_BAD     = 4'd3,
        STS_ERASED     = 4'd4,
        STS_PROGRAMMED = 4'd5,
        STS_ERASE_TO   = 4'd6,
        STS_PROG_TO    = 4'd7,
        STS_BUSY       = 4'd8,
        STS_UNEXPECTED = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        BUS_NONE  = 2'd0,
        BUS_WRITE = 2'd1,
        BUS_READ  = 2'd2
    } t_bus_op;

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_ID_MAKER   = 6'b000010,
        PH_ID_DEVICE  = 6'b000100,
        PH_ERASE_ARM  = 6'b001000,
        PH_ERASE_POLL = 6'b010000,
        PH_PROG_POLL  = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        SEQ_NONE     = 3'd0,
        SEQ_IDENT    = 3'd1,
        SEQ_RESET    = 3'd2,
        SEQ_ERASE    = 3'd3,
        SEQ_PROG     = 3'd4,
        SEQ_READ     = 3'd5,
        SEQ_ERASE_GO = 3'd6
    } t_seq;

    typedef struct packed {
        t_seq        kind;
        logic [16:0] addr;
        logic [7:0]  data;
        t_status     status;
        logic [17:0] mcount;
        logic [16:0] first;
        logic        seen;
    } t_plan;

    typedef struct packed {
        t_bus_op     op;
        logic [16:0] addr;
        logic [7:0]  data;
    } t_bus;

    typedef struct packed {
        t_bus        bus;
        t_status     status;
        logic [17:0] mcount;
        logic [16:0] first;
        logic        seen;
        logic        last;
    } t_item;

    function automatic logic [2:0] seq_len(input t_seq kind);
        logic [2:0] n;
        case (kind)
            SEQ_IDENT:    n = 3'd4;
            SEQ_RESET:    n = 3'd3;
            SEQ_ERASE:    n = 3'd5;
            SEQ_PROG:     n = 3'd5;
            SEQ_ERASE_GO: n = 3'd2;
            default:      n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic t_bus bus_wr(input logic [16:0] a, input logic [7:0] d);
        t_bus b;
        b.op   = BUS_WRITE;
        b.addr = a & AddrMask;
        b.data = d;
        return b;
    endfunction

    function automatic t_bus bus_rd(input logic [16:0] a);
        t_bus b;
        b.op   = BUS_READ;
        b.addr = a & AddrMask;
        b.data = 8'd0;
        return b;
    endfunction

    // Bus cycle number idx of a sequence.
    function automatic t_bus seq_item(input t_seq kind, input logic [2:0] idx,
                                      input logic [16:0] addr, input logic [7:0] data);
        t_bus b;
        b = '{op: BUS_NONE, addr: 17'd0, data: 8'd0};
        case (kind)
            SEQ_IDENT, SEQ_RESET, SEQ_ERASE, SEQ_PROG: begin
                case (idx)
                    3'd0: b = bus_wr(CmdAddrA, CmdUnlockA);
                    3'd1: b = bus_wr(CmdAddrB, CmdUnlockB);
                    3'd2: begin
                        case (kind)
                            SEQ_IDENT: b = bus_wr(CmdAddrA, CmdAutoId);
                            SEQ_RESET: b = bus_wr(CmdAddrA, CmdResetRd);
                            SEQ_ERASE: b = bus_wr(CmdAddrA, CmdErase);
                            default:   b = bus_wr(CmdAddrA, CmdProgram);
                        endcase
                    end
                    3'd3: begin
                        case (kind)
                            SEQ_IDENT: b = bus_rd(17'd0);
                            SEQ_ERASE: b = bus_wr(CmdAddrA, CmdUnlockA);
                            default:   b = bus_wr(addr, data);
                        endcase
                    end
                    default: begin
                        if (kind == SEQ_ERASE) begin
                            b = bus_wr(CmdAddrB, CmdUnlockB);
                        end else begin
                            b = bus_rd(addr);
                        end
                    end
                endcase
            end
            SEQ_READ: b = bus_rd(addr);
            SEQ_ERASE_GO: begin
                if (idx == 3'd0) begin
                    b = bus_wr(CmdAddrA, CmdChipEra);
                end else begin
                    b = bus_rd(17'd0);
                end
            end
            default: b = '{op: BUS_NONE, addr: 17'd0, data: 8'd0};
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/jfps_front.sv =====
// ----------------------------------------------------------------------------
// jfps_front
// Command decode, sequence phase, poll counting and compare counters.
// ----------------------------------------------------------------------------
module jfps_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_accept,
    input  logic [2:0]            i_mode,
    input  logic [16:0]           i_address,
    input  logic [7:0]            i_data,
    input  logic [7:0]            i_read_data,
    output jfps_pkg::t_plan       o_plan
);

    logic [17:0] r_payload_len;
    logic [31:0] r_erase_limit;
    logic [31:0] r_prog_limit;
    logic [7:0]  r_exp_maker;
    logic [7:0]  r_exp_device;

    jfps_pkg::t_phase r_phase, n_phase;
    logic [16:0] r_poll_addr, n_poll_addr;
    logic [7:0]  r_poll_exp, n_poll_exp;
    logic [31:0] r_spin, n_spin;
    logic [7:0]  r_maker, n_maker;
    logic [17:0] r_mtotal, n_mtotal;
    logic [16:0] r_first, n_first;
    logic        r_found, n_found;

    logic [31:0] poll_limit;
    logic [7:0]  want;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_len <= jfps_pkg::PayloadReset;
            r_erase_limit <= jfps_pkg::ErasePollReset;
            r_prog_limit  <= jfps_pkg::ProgPollReset;
            r_exp_maker   <= jfps_pkg::MakerReset;
            r_exp_device  <= jfps_pkg::DeviceReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jfps_pkg::CFG_PAYLOAD_LENGTH:  r_payload_len <= i_cfg_data[17:0];
                jfps_pkg::CFG_ERASE_LIMIT:     r_erase_limit <= i_cfg_data;
                jfps_pkg::CFG_PROGRAM_LIMIT:   r_prog_limit  <= i_cfg_data;
                jfps_pkg::CFG_EXPECTED_MAKER:  r_exp_maker   <= i_cfg_data[7:0];
                jfps_pkg::CFG_EXPECTED_DEVICE: r_exp_device  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_poll_addr = r_poll_addr;
        n_poll_exp  = r_poll_exp;
        n_spin      = r_spin;
        n_maker     = r_maker;
        n_mtotal    = r_mtotal;
        n_first     = r_first;
        n_found     = r_found;
        o_plan.kind   = jfps_pkg::SEQ_NONE;
        o_plan.addr   = 17'd0;
        o_plan.data   = 8'd0;
        o_plan.status = jfps_pkg::STS_ACCEPTED;
        poll_limit = (r_phase == jfps_pkg::PH_ERASE_POLL) ? r_erase_limit : r_prog_limit;
        want = ({1'b0, i_address} < r_payload_len) ? i_data : jfps_pkg::ErasedByte;

        unique case (jfps_pkg::t_mode'(i_mode))
            jfps_pkg::MODE_IDENTIFY: begin
                if (r_phase != jfps_pkg::PH_IDLE) begin
                    o_plan.status = jfps_pkg::STS_BUSY;
                end else begin
                    o_plan.kind   = jfps_pkg::SEQ_IDENT;
                    o_plan.status = jfps_pkg::STS_POLLING;
                    n_phase       = jfps_pkg::PH_ID_MAKER;
                end
            end
            jfps_pkg::MODE_RESET: begin
                o_plan.kind = jfps_pkg::SEQ_RESET;
                n_phase     = jfps_pkg::PH_IDLE;
                n_spin      = 32'd0;
            end
            jfps_pkg::MODE_ERASE: begin
                if (r_phase != jfps_pkg::PH_IDLE) begin
                    o_plan.status = jfps_pkg::STS_BUSY;
                end else begin
                    o_plan.kind   = jfps_pkg::SEQ_ERASE;
                    o_plan.status = jfps_pkg::STS_POLLING;
                    n_phase       = jfps_pkg::PH_ERASE_ARM;
                end
            end
            jfps_pkg::MODE_PROGRAM: begin
                if (r_phase != jfps_pkg::PH_IDLE) begin
                    o_plan.status = jfps_pkg::STS_BUSY;
                end else if (i_data == jfps_pkg::ErasedByte) begin
                    o_plan.status = jfps_pkg::STS_PROGRAMMED;
                end else begin
                    o_plan.kind   = jfps_pkg::SEQ_PROG;
                    o_plan.addr   = i_address;
                    o_plan.data   = i_data;
                    o_plan.status = jfps_pkg::STS_POLLING;
                    n_poll_addr   = i_address;
                    n_poll_exp    = i_data;
                    n_spin        = 32'd0;
                    n_phase       = jfps_pkg::PH_PROG_POLL;
                end
            end
            jfps_pkg::MODE_RESPONSE: begin
                unique case (r_phase)
                    jfps_pkg::PH_ID_MAKER: begin
                        n_maker       = i_read_data;
                        o_plan.kind   = jfps_pkg::SEQ_READ;
                        o_plan.addr   = 17'd1;
                        o_plan.status = jfps_pkg::STS_POLLING;
                        n_phase       = jfps_pkg::PH_ID_DEVICE;
                    end
                    jfps_pkg::PH_ID_DEVICE: begin
                        o_plan.kind   = jfps_pkg::SEQ_RESET;
                        o_plan.status = (r_maker == r_exp_maker && i_read_data == r_exp_device)
                                        ? jfps_pkg::STS_ID_OK : jfps_pkg::STS_ID_BAD;
                        n_phase       = jfps_pkg::PH_IDLE;
                    end
                    jfps_pkg::PH_ERASE_ARM: begin
                        o_plan.kind   = jfps_pkg::SEQ_ERASE_GO;
                        o_plan.status = jfps_pkg::STS_POLLING;
                        n_spin        = 32'd0;
                        n_phase       = jfps_pkg::PH_ERASE_POLL;
                    end
                    jfps_pkg::PH_ERASE_POLL, jfps_pkg::PH_PROG_POLL: begin
                        if ((r_phase == jfps_pkg::PH_ERASE_POLL &&
                             i_read_data == jfps_pkg::ErasedByte) ||
                            (r_phase == jfps_pkg::PH_PROG_POLL &&
                             i_read_data == r_poll_exp)) begin
                            o_plan.status = (r_phase == jfps_pkg::PH_ERASE_POLL)
                                            ? jfps_pkg::STS_ERASED : jfps_pkg::STS_PROGRAMMED;
                            n_phase       = jfps_pkg::PH_IDLE;
                            n_spin        = 32'd0;
                        end else if (r_spin >= poll_limit) begin
                            o_plan.kind   = jfps_pkg::SEQ_RESET;
                            o_plan.status = (r_phase == jfps_pkg::PH_ERASE_POLL)
                                            ? jfps_pkg::STS_ERASE_TO : jfps_pkg::STS_PROG_TO;
                            n_phase       = jfps_pkg::PH_IDLE;
                            n_spin        = 32'd0;
                        end else begin
                            o_plan.kind   = jfps_pkg::SEQ_READ;
                            o_plan.addr   = (r_phase == jfps_pkg::PH_ERASE_POLL)
                                            ? 17'd0 : r_poll_addr;
                            o_plan.status = jfps_pkg::STS_POLLING;
                            n_spin        = r_spin + 32'd1;
                        end
                    end
                    default: o_plan.status = jfps_pkg::STS_UNEXPECTED;
                endcase
            end
            jfps_pkg::MODE_COMPARE: begin
                if (i_read_data != want) begin
                    if (!r_found) begin
                        n_first = i_address;
                        n_found = 1'b1;
                    end
                    if (r_mtotal != jfps_pkg::CountMax) begin
                        n_mtotal = r_mtotal + 18'd1;
                    end
                end
            end
            jfps_pkg::MODE_CLEAR: begin
                n_mtotal = 18'd0;
                n_first  = 17'd0;
                n_found  = 1'b0;
            end
            default: o_plan.status = jfps_pkg::STS_UNEXPECTED;
        endcase

        o_plan.mcount = n_mtotal;
        o_plan.first  = n_found ? n_first : 17'd0;
        o_plan.seen   = n_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jfps_pkg::PH_IDLE;
            r_poll_addr <= 17'd0;
            r_poll_exp  <= 8'd0;
            r_spin      <= 32'd0;
            r_maker     <= 8'd0;
            r_mtotal    <= 18'd0;
            r_first     <= 17'd0;
            r_found     <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_poll_addr <= n_poll_addr;
            r_poll_exp  <= n_poll_exp;
            r_spin      <= n_spin;
            r_maker     <= n_maker;
            r_mtotal    <= n_mtotal;
            r_first     <= n_first;
            r_found     <= n_found;
        end
    end

endmodule

// ===== rtl/jfps_queue.sv =====
// ----------------------------------------------------------------------------
// jfps_queue
// Short queue of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module jfps_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  jfps_pkg::t_plan       i_plan,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output jfps_pkg::t_plan       o_plan
);

    jfps_pkg::t_plan r_mem [jfps_pkg::QueueDepth];
    logic [jfps_pkg::QPtrBits-1:0] r_wptr;
    logic [jfps_pkg::QPtrBits-1:0] r_rptr;
    logic [jfps_pkg::QCntBits-1:0] r_count;

    assign o_full  = (r_count == jfps_pkg::QCntBits'(jfps_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_plan  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/jfps_back.sv =====
// ----------------------------------------------------------------------------
// jfps_back
// Expands queued commands into bus cycles, one result per clock unless stalled.
// ----------------------------------------------------------------------------
module jfps_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_plan_valid,
    input  jfps_pkg::t_plan       i_plan,
    output logic                  o_plan_pop,
    input  logic                  i_pop,
    output logic                  o_valid,
    output jfps_pkg::t_item       o_item
);

    logic [2:0]      r_step;
    logic            r_valid;
    jfps_pkg::t_item r_item;
    jfps_pkg::t_item n_item;
    logic            load;
    logic            is_last;

    assign load    = !r_valid || i_pop;
    assign is_last = (r_step == jfps_pkg::seq_len(i_plan.kind) - 3'd1);
    assign o_plan_pop = load && i_plan_valid && is_last;

    always_comb begin
        n_item.bus    = jfps_pkg::seq_item(i_plan.kind, r_step, i_plan.addr, i_plan.data);
        n_item.status = i_plan.status;
        n_item.mcount = i_plan.mcount;
        n_item.first  = i_plan.first;
        n_item.seen   = i_plan.seen;
        n_item.last   = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (load && i_plan_valid) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_plan_valid;
            if (i_plan_valid) begin
                r_step <= is_last ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/jedec_flash_program_sequencer.sv =====
// ----------------------------------------------------------------------------
// jedec_flash_program_sequencer
// Command sequencer for a byte-wide JEDEC parallel NOR flash.
// ----------------------------------------------------------------------------
// Each command request yields one to five results, one per bus cycle in bus
// order (a single no-cycle result when nothing goes on the bus). The front
// end decodes a command combinationally and registers the sequence state
// when the request is accepted, so a request can be taken every clock while
// the four-entry command queue has room. The back end drains the queue
// through its output register at one result per clock while results are
// popped; that expander sets the sustained rate. Poll replies are fed back
// as read-response requests. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module jedec_flash_program_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_mode,
    input  logic [16:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_read_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_bus_op,
    output logic [16:0] o_bus_address,
    output logic [7:0]  o_bus_data,
    output logic [3:0]  o_status,
    output logic [17:0] o_mismatch_count,
    output logic [16:0] o_first_mismatch,
    output logic        o_mismatch_seen,
    output logic        o_last
);

    logic            accept;
    logic            q_pop;
    logic            q_valid;
    logic            out_valid;
    jfps_pkg::t_plan fe_plan;
    jfps_pkg::t_plan q_plan;
    jfps_pkg::t_item item;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    jfps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_address   (i_address),
        .i_data      (i_data),
        .i_read_data (i_read_data),
        .o_plan      (fe_plan)
    );

    jfps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_plan  (fe_plan),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_plan  (q_plan)
    );

    jfps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (q_valid),
        .i_plan       (q_plan),
        .o_plan_pop   (q_pop),
        .i_pop        (pop),
        .o_valid      (out_valid),
        .o_item       (item)
    );

    assign empty            = !out_valid;
    assign o_bus_op         = item.bus.op;
    assign o_bus_address    = item.bus.addr;
    assign o_bus_data       = item.bus.data;
    assign o_status         = item.status;
    assign o_mismatch_count = item.mcount;
    assign o_first_mismatch = item.first;
    assign o_mismatch_seen  = item.seen;
    assign o_last           = item.last;

    a_none_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bus_op == jfps_pkg::BUS_NONE) |-> o_last)
        else $error("no-cycle result not marked last");

    a_data_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bus_op != jfps_pkg::BUS_WRITE) |-> (o_bus_data == 8'd0))
        else $error("bus data on a non-write cycle");

    a_first_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_mismatch_seen) |-> (o_first_mismatch == 17'd0))
        else $error("first mismatch address without a mismatch");

    a_queue_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

endmodule

// ===== bench/jedec_flash_program_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// jedec_flash_program_sequencer_test
// Self-checking bench for the JEDEC flash command sequencer.
// ----------------------------------------------------------------------------
// Commands are pushed with random gaps and results are popped with random
// stalls. A scoreboard class keeps its own copy of the sequence state and the
// registers, expands each accepted request into the bus cycles it should
// produce, and checks every popped result field by field in order.
// Stimulus: a directed pass over every command and corner, then mostly
// well-formed identify, erase and program sequences with random replies under
// several register settings, extremes included, one of them with a long
// output stall.
// ----------------------------------------------------------------------------
module jedec_flash_program_sequencer_test;

    localparam int CycleLimit   = 400000;
    localparam int HoldCycles   = 80;
    localparam int PhaseItems   = 60;
    localparam logic [2:0] ModeUndefined = 3'd7;
    localparam logic [2:0] CfgSpare      = 3'd7;

    class bus_cycle_board;
        logic [17:0] payload_len;
        logic [31:0] erase_limit;
        logic [31:0] program_limit;
        logic [7:0]  want_maker;
        logic [7:0]  want_device;
        jfps_pkg::t_phase phase;
        logic [16:0] poll_addr;
        logic [7:0]  poll_byte;
        logic [31:0] spins;
        logic [7:0]  maker_got;
        logic [17:0] bad_total;
        logic [16:0] first_bad;
        logic        bad_found;
        jfps_pkg::t_bus  step_cycles[$];
        jfps_pkg::t_item cycles_due[$];
        int          errors;
        int          commands;
        int          checked;
        int          status_hits[16];

        function new();
            payload_len   = jfps_pkg::PayloadReset;
            erase_limit   = jfps_pkg::ErasePollReset;
            program_limit = jfps_pkg::ProgPollReset;
            want_maker    = jfps_pkg::MakerReset;
            want_device   = jfps_pkg::DeviceReset;
            phase         = jfps_pkg::PH_IDLE;
            poll_addr     = '0;
            poll_byte     = '0;
            spins         = '0;
            maker_got     = '0;
            bad_total     = '0;
            first_bad     = '0;
            bad_found     = 1'b0;
            errors        = 0;
            commands      = 0;
            checked       = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                jfps_pkg::CFG_PAYLOAD_LENGTH:  payload_len   = val[17:0];
                jfps_pkg::CFG_ERASE_LIMIT:     erase_limit   = val;
                jfps_pkg::CFG_PROGRAM_LIMIT:   program_limit = val;
                jfps_pkg::CFG_EXPECTED_MAKER:  want_maker    = val[7:0];
                jfps_pkg::CFG_EXPECTED_DEVICE: want_device   = val[7:0];
                default: ;
            endcase
        endfunction

        function void add_cycle(jfps_pkg::t_bus_op op, logic [16:0] a, logic [7:0] d);
            jfps_pkg::t_bus b;
            b.op   = op;
            b.addr = (op == jfps_pkg::BUS_NONE) ? 17'd0 : (a & jfps_pkg::AddrMask);
            b.data = (op == jfps_pkg::BUS_WRITE) ? d : 8'd0;
            step_cycles.push_back(b);
        endfunction

        function void cmd_write(logic [7:0] code);
            add_cycle(jfps_pkg::BUS_WRITE, jfps_pkg::CmdAddrA, code);
        endfunction

        function void unlock();
            add_cycle(jfps_pkg::BUS_WRITE, jfps_pkg::CmdAddrA, jfps_pkg::CmdUnlockA);
            add_cycle(jfps_pkg::BUS_WRITE, jfps_pkg::CmdAddrB, jfps_pkg::CmdUnlockB);
        endfunction

        function void reset_read();
            unlock();
            cmd_write(jfps_pkg::CmdResetRd);
        endfunction

        // Failed poll; on timeout the flash is put back in read mode.
        function bit poll_missed(logic [31:0] limit);
            if (spins >= limit) begin
                reset_read();
                phase = jfps_pkg::PH_IDLE;
                spins = '0;
                return 1'b1;
            end
            spins++;
            return 1'b0;
        endfunction

        function void note_command(logic [2:0] mode, logic [16:0] addr,
                                   logic [7:0] data, logic [7:0] rdat);
            jfps_pkg::t_status sts;
            jfps_pkg::t_item   it;
            logic [7:0]        want;
            sts = jfps_pkg::STS_ACCEPTED;
            step_cycles.delete();
            commands++;
            case (mode)
                jfps_pkg::MODE_IDENTIFY: begin
                    if (phase != jfps_pkg::PH_IDLE) begin
                        sts = jfps_pkg::STS_BUSY;
                    end else begin
                        unlock();
                        cmd_write(jfps_pkg::CmdAutoId);
                        add_cycle(jfps_pkg::BUS_READ, 17'd0, 8'd0);
                        phase = jfps_pkg::PH_ID_MAKER;
                        sts   = jfps_pkg::STS_POLLING;
                    end
                end
                jfps_pkg::MODE_RESET: begin
                    reset_read();
                    phase = jfps_pkg::PH_IDLE;
                    spins = '0;
                end
                jfps_pkg::MODE_ERASE: begin
                    if (phase != jfps_pkg::PH_IDLE) begin
                        sts = jfps_pkg::STS_BUSY;
                    end else begin
                        unlock();
                        cmd_write(jfps_pkg::CmdErase);
                        unlock();
                        phase = jfps_pkg::PH_ERASE_ARM;
                        sts   = jfps_pkg::STS_POLLING;
                    end
                end
                jfps_pkg::MODE_PROGRAM: begin
                    if (phase != jfps_pkg::PH_IDLE) begin
                        sts = jfps_pkg::STS_BUSY;
                    end else if (data == jfps_pkg::ErasedByte) begin
                        sts = jfps_pkg::STS_PROGRAMMED;
                    end else begin
                        unlock();
                        cmd_write(jfps_pkg::CmdProgram);
                        add_cycle(jfps_pkg::BUS_WRITE, addr, data);
                        add_cycle(jfps_pkg::BUS_READ, addr, 8'd0);
                        poll_addr = addr;
                        poll_byte = data;
                        spins     = '0;
                        phase     = jfps_pkg::PH_PROG_POLL;
                        sts       = jfps_pkg::STS_POLLING;
                    end
                end
                jfps_pkg::MODE_RESPONSE: begin
                    case (phase)
                        jfps_pkg::PH_ID_MAKER: begin
                            maker_got = rdat;
                            add_cycle(jfps_pkg::BUS_READ, 17'd1, 8'd0);
                            phase = jfps_pkg::PH_ID_DEVICE;
                            sts   = jfps_pkg::STS_POLLING;
                        end
                        jfps_pkg::PH_ID_DEVICE: begin
                            sts = (maker_got == want_maker && rdat == want_device) ?
                                  jfps_pkg::STS_ID_OK : jfps_pkg::STS_ID_BAD;
                            reset_read();
                            phase = jfps_pkg::PH_IDLE;
                        end
                        jfps_pkg::PH_ERASE_ARM: begin
                            cmd_write(jfps_pkg::CmdChipEra);
                            add_cycle(jfps_pkg::BUS_READ, 17'd0, 8'd0);
                            spins = '0;
                            phase = jfps_pkg::PH_ERASE_POLL;
                            sts   = jfps_pkg::STS_POLLING;
                        end
                        jfps_pkg::PH_ERASE_POLL: begin
                            if (rdat == jfps_pkg::ErasedByte) begin
                                phase = jfps_pkg::PH_IDLE;
                                spins = '0;
                                sts   = jfps_pkg::STS_ERASED;
                            end else if (poll_missed(erase_limit)) begin
                                sts = jfps_pkg::STS_ERASE_TO;
                            end else begin
                                add_cycle(jfps_pkg::BUS_READ, 17'd0, 8'd0);
                                sts = jfps_pkg::STS_POLLING;
                            end
                        end
                        jfps_pkg::PH_PROG_POLL: begin
                            if (rdat == poll_byte) begin
                                phase = jfps_pkg::PH_IDLE;
                                spins = '0;
                                sts   = jfps_pkg::STS_PROGRAMMED;
                            end else if (poll_missed(program_limit)) begin
                                sts = jfps_pkg::STS_PROG_TO;
                            end else begin
                                add_cycle(jfps_pkg::BUS_READ, poll_addr, 8'd0);
                                sts = jfps_pkg::STS_POLLING;
                            end
                        end
                        default: sts = jfps_pkg::STS_UNEXPECTED;
                    endcase
                end
                jfps_pkg::MODE_COMPARE: begin
                    want = (addr < payload_len) ? data : jfps_pkg::ErasedByte;
                    if (rdat != want) begin
                        if (!bad_found) begin
                            first_bad = addr;
                            bad_found = 1'b1;
                        end
                        if (bad_total != jfps_pkg::CountMax) bad_total++;
                    end
                end
                jfps_pkg::MODE_CLEAR: begin
                    bad_total = '0;
                    first_bad = '0;
                    bad_found = 1'b0;
                end
                default: sts = jfps_pkg::STS_UNEXPECTED;
            endcase
            if (step_cycles.size() == 0) add_cycle(jfps_pkg::BUS_NONE, 17'd0, 8'd0);
            status_hits[sts]++;
            foreach (step_cycles[k]) begin
                it.bus    = step_cycles[k];
                it.status = sts;
                it.mcount = bad_total;
                it.first  = bad_found ? first_bad : 17'd0;
                it.seen   = bad_found;
                it.last   = (k == step_cycles.size() - 1);
                cycles_due.push_back(it);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30) $display("ERROR: %s", msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h at result %0d",
                                 name, got, want, checked));
        endtask

        task check_cycle(jfps_pkg::t_item got);
            jfps_pkg::t_item want;
            if (cycles_due.size() == 0) begin
                report($sformatf("result with nothing pending: op %0d status %0d",
                                 got.bus.op, got.status));
                return;
            end
            want = cycles_due.pop_front();
            check_field("bus_op", got.bus.op, want.bus.op);
            check_field("bus_address", got.bus.addr, want.bus.addr);
            check_field("bus_data", got.bus.data, want.bus.data);
            check_field("status", got.status, want.status);
            check_field("mismatch_count", got.mcount, want.mcount);
            check_field("first_mismatch", got.first, want.first);
            check_field("mismatch_seen", got.seen, want.seen);
            check_field("last", got.last, want.last);
            checked++;
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        push        = 1'b0;
    logic        full;
    logic [2:0]  i_mode      = '0;
    logic [16:0] i_address   = '0;
    logic [7:0]  i_data      = '0;
    logic [7:0]  i_read_data = '0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [1:0]  o_bus_op;
    logic [16:0] o_bus_address;
    logic [7:0]  o_bus_data;
    logic [3:0]  o_status;
    logic [17:0] o_mismatch_count;
    logic [16:0] o_first_mismatch;
    logic        o_mismatch_seen;
    logic        o_last;

    bus_cycle_board board = new();
    bit steady   = 1'b0;
    bit hold_ask = 1'b0;
    int sent     = 0;
    int cycle_count = 0;

    jedec_flash_program_sequencer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_mode           (i_mode),
        .i_address        (i_address),
        .i_data           (i_data),
        .i_read_data      (i_read_data),
        .empty            (empty),
        .pop              (pop),
        .o_bus_op         (o_bus_op),
        .o_bus_address    (o_bus_address),
        .o_bus_data       (o_bus_data),
        .o_status         (o_status),
        .o_mismatch_count (o_mismatch_count),
        .o_first_mismatch (o_first_mismatch),
        .o_mismatch_seen  (o_mismatch_seen),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d clocks", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [16:0] rand_addr();
        return 17'($urandom_range(0, 17'h1FFFF));
    endfunction

    // Result side: random stalls, plus one long hold when asked.
    initial begin : result_side
        int              gap_left;
        int              hold_left;
        jfps_pkg::t_item got;
        gap_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.bus.op   = jfps_pkg::t_bus_op'(o_bus_op);
                got.bus.addr = o_bus_address;
                got.bus.data = o_bus_data;
                got.status   = jfps_pkg::t_status'(o_status);
                got.mcount   = o_mismatch_count;
                got.first    = o_first_mismatch;
                got.seen     = o_mismatch_seen;
                got.last     = o_last;
                board.check_cycle(got);
                gap_left = draw_gap();
            end
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_cmd(input logic [2:0] mode, input logic [16:0] addr,
                            input logic [7:0] data, input logic [7:0] rdat);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode      <= mode;
        i_address   <= addr;
        i_data      <= data;
        i_read_data <= rdat;
        push        <= 1'b1;
        do @(posedge i_clk); while (full);
        board.note_command(mode, addr, data, rdat);
        sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        while (board.cycles_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] payload, input logic [31:0] elimit,
                                  input logic [31:0] plimit, input logic [31:0] maker,
                                  input logic [31:0] device);
        logic [2:0]  idx[6];
        logic [31:0] val[6];
        idx = '{jfps_pkg::CFG_PAYLOAD_LENGTH, jfps_pkg::CFG_ERASE_LIMIT,
                jfps_pkg::CFG_PROGRAM_LIMIT, jfps_pkg::CFG_EXPECTED_MAKER,
                jfps_pkg::CFG_EXPECTED_DEVICE, CfgSpare};
        val = '{payload, elimit, plimit, maker, device, $urandom()};
        for (int k = 0; k < 6; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            board.set_reg(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_compare();
        logic [16:0] a;
        logic [7:0]  d;
        logic [7:0]  w;
        a = rand_addr();
        d = rand_byte();
        w = (a < board.payload_len) ? d : jfps_pkg::ErasedByte;
        send_cmd(jfps_pkg::MODE_COMPARE, a, d, chance(50) ? w : rand_byte());
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 9))
            0, 1, 2: send_compare();
            3: send_cmd(jfps_pkg::MODE_CLEAR, rand_addr(), rand_byte(), rand_byte());
            4: send_cmd(jfps_pkg::MODE_RESET, rand_addr(), rand_byte(), rand_byte());
            5: send_cmd(jfps_pkg::MODE_IDENTIFY, rand_addr(), rand_byte(), rand_byte());
            6: send_cmd(jfps_pkg::MODE_ERASE, rand_addr(), rand_byte(), rand_byte());
            7: send_cmd(jfps_pkg::MODE_PROGRAM, rand_addr(), rand_byte(), rand_byte());
            8: send_cmd(jfps_pkg::MODE_RESPONSE, rand_addr(), rand_byte(), rand_byte());
            default: send_cmd(ModeUndefined, rand_addr(), rand_byte(), rand_byte());
        endcase
    endtask

    // Reply to an open sequence until it finishes, with the odd stray request.
    task automatic answer_until_idle();
        logic [7:0] rd;
        while (board.phase != jfps_pkg::PH_IDLE) begin
            if (chance(6)) begin
                send_noise();
            end else begin
                case (board.phase)
                    jfps_pkg::PH_ID_MAKER:
                        rd = chance(60) ? board.want_maker : rand_byte();
                    jfps_pkg::PH_ID_DEVICE:
                        rd = chance(60) ? board.want_device : rand_byte();
                    jfps_pkg::PH_PROG_POLL:
                        rd = chance(25) ? board.poll_byte : rand_byte();
                    default:
                        rd = chance(25) ? jfps_pkg::ErasedByte : rand_byte();
                endcase
                send_cmd(jfps_pkg::MODE_RESPONSE, rand_addr(), rand_byte(), rd);
            end
        end
    endtask

    task automatic run_random(input int budget);
        int stop;
        int r;
        stop = sent + budget;
        while (sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_cmd(jfps_pkg::MODE_PROGRAM, rand_addr(),
                         chance(6) ? jfps_pkg::ErasedByte : rand_byte(), rand_byte());
                answer_until_idle();
            end else if (r < 45) begin
                send_cmd(jfps_pkg::MODE_ERASE, rand_addr(), rand_byte(), rand_byte());
                answer_until_idle();
            end else if (r < 60) begin
                send_cmd(jfps_pkg::MODE_IDENTIFY, rand_addr(), rand_byte(), rand_byte());
                answer_until_idle();
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic crowd_output();
        hold_ask = 1'b1;
        steady   = 1'b1;
        repeat (24) send_compare();
        steady   = 1'b0;
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass under reset register values
        send_cmd(jfps_pkg::MODE_RESET, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'h1FFFF, 8'hFF, 8'hFF);
        send_cmd(ModeUndefined, 17'h1FFFF, 8'hFF, 8'hFF);
        send_cmd(jfps_pkg::MODE_IDENTIFY, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_IDENTIFY, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, jfps_pkg::MakerReset);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, jfps_pkg::DeviceReset);
        send_cmd(jfps_pkg::MODE_IDENTIFY, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, jfps_pkg::DeviceReset);
        send_cmd(jfps_pkg::MODE_PROGRAM, 17'h1FFFF, jfps_pkg::ErasedByte, 8'h00);
        send_cmd(jfps_pkg::MODE_PROGRAM, 17'h1FFFF, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_ERASE, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, 8'hFF);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_ERASE, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, 8'h7F);
        send_cmd(jfps_pkg::MODE_RESPONSE, 17'd0, 8'h00, jfps_pkg::ErasedByte);
        send_cmd(jfps_pkg::MODE_PROGRAM, 17'd0, 8'hFE, 8'h00);
        send_cmd(jfps_pkg::MODE_RESET, 17'd0, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_COMPARE, 17'h1FFFF, 8'h00, 8'h00);
        send_cmd(jfps_pkg::MODE_COMPARE, 17'd0, 8'h5A, 8'hA5);
        send_cmd(jfps_pkg::MODE_COMPARE, 17'h1FFFF, 8'hFF, 8'h12);
        send_cmd(jfps_pkg::MODE_CLEAR, 17'd0, 8'h00, 8'h00);
        settle();

        apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_random(PhaseItems);
        settle();

        apply_settings(32'h3FFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFF, 32'hFF);
        crowd_output();
        run_random(PhaseItems);
        settle();

        for (int s = 0; s < 4; s++) begin
            if (s == 0)
                apply_settings(jfps_pkg::PayloadReset, jfps_pkg::ErasePollReset,
                               jfps_pkg::ProgPollReset, jfps_pkg::MakerReset,
                               jfps_pkg::DeviceReset);
            else
                apply_settings($urandom_range(1, 131072), $urandom_range(1, 6),
                               $urandom_range(1, 6), rand_byte(), rand_byte());
            steady = (s == 2);
            run_random(PhaseItems);
            steady = 1'b0;
            settle();
        end

        $display("Covered %0d commands and %0d result items in %0d clocks.",
                 board.commands, board.checked, cycle_count);
        $display("Seen: id ok %0d, id bad %0d, erased %0d, programmed %0d, %s %0d/%0d, busy %0d",
                 board.status_hits[jfps_pkg::STS_ID_OK],
                 board.status_hits[jfps_pkg::STS_ID_BAD],
                 board.status_hits[jfps_pkg::STS_ERASED],
                 board.status_hits[jfps_pkg::STS_PROGRAMMED],
                 "erase/program timeouts", board.status_hits[jfps_pkg::STS_ERASE_TO],
                 board.status_hits[jfps_pkg::STS_PROG_TO],
                 board.status_hits[jfps_pkg::STS_BUSY]);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
